>>> rtl/core/dpfth_pkg.sv
package dpfth_pkg;

  localparam int TEMP_W = 11;
  localparam int HUM_W  = 7;
  localparam int DEW_W  = 15;

  localparam int FRAC_BITS_DEF = 24;

  // Magnus coefficients, scaled by ten
  localparam logic [6:0]  A10_POS = 7'd75;
  localparam logic [6:0]  A10_NEG = 7'd76;
  localparam logic [11:0] B10_POS = 12'd2373;
  localparam logic [11:0] B10_NEG = 12'd2407;
  // 100 * b10
  localparam logic [17:0] B100_POS = 18'd237300;
  localparam logic [17:0] B100_NEG = 18'd240700;

  localparam int DEW_MAX = 8000;
  localparam int DEW_MIN = -10000;

  localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;

  // log10(h/100) in Q(fb), bitwise log2 at 32 fractional bits
  function automatic logic signed [63:0] log10_rel(input int h, input int fb);
    int n;
    int s;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] mag;
    longint l32;
    n = 0;
    frac = 64'd0;
    if (h == 0) begin
      return 64'sd0;
    end
    for (int i = 0; i < 6; i++) begin
      if ((h >> (i + 1)) != 0) begin
        n = i + 1;
      end
    end
    m = 64'(h) << (30 - n);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (31 - i));
      end
    end
    l32 = longint'(64'(n) * LOG10_2_Q32)
        + longint'((frac * LOG10_2_Q32 + (64'd1 << 31)) >> 32)
        - (longint'(2) <<< 32);
    s = 32 - fb;
    if (s == 0) begin
      return l32;
    end
    mag = (l32 < 0) ? 64'(-l32) : 64'(l32);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (l32 < 0) ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

>>> rtl/core/dpfth_div_cell.sv
module dpfth_div_cell #(
  parameter int DW  = 16,
  parameter int QW  = 27,
  parameter int SBW = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           prev_valid,
  input  logic [DW-1:0]  prev_rem,
  input  logic [QW-1:0]  prev_sh,
  input  logic [DW-1:0]  prev_den,
  input  logic [SBW-1:0] prev_side,
  output logic           valid,
  output logic [DW-1:0]  rem,
  output logic [QW-1:0]  sh,
  output logic [DW-1:0]  den,
  output logic [SBW-1:0] side
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {prev_rem, prev_sh[QW-1]};
  assign diff  = trial - {1'b0, prev_den};
  assign ge    = (trial >= {1'b0, prev_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      sh   <= {prev_sh[QW-2:0], ge};
      den  <= prev_den;
      side <= prev_side;
    end
  end

endmodule

>>> rtl/core/dpfth_div.sv
module dpfth_div #(
  parameter int DW  = 16,
  parameter int QW  = 27,
  parameter int SBW = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QW+DW-1:0]  in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [SBW-1:0]    in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo,
  output logic [SBW-1:0]    out_side
);

  logic           lk_valid [QW+1];
  logic [DW-1:0]  lk_rem   [QW+1];
  logic [QW-1:0]  lk_sh    [QW+1];
  logic [DW-1:0]  lk_den   [QW+1];
  logic [SBW-1:0] lk_side  [QW+1];

  // dividend high part is below the divisor; low part shifts out as quotient shifts in
  assign lk_valid[0] = in_valid;
  assign lk_rem[0]   = in_num[QW+DW-1:QW];
  assign lk_sh[0]    = in_num[QW-1:0];
  assign lk_den[0]   = in_den;
  assign lk_side[0]  = in_side;

  for (genvar gi = 0; gi < QW; gi++) begin : g_cell
    dpfth_div_cell #(.DW(DW), .QW(QW), .SBW(SBW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (lk_valid[gi]),
      .prev_rem   (lk_rem[gi]),
      .prev_sh    (lk_sh[gi]),
      .prev_den   (lk_den[gi]),
      .prev_side  (lk_side[gi]),
      .valid      (lk_valid[gi+1]),
      .rem        (lk_rem[gi+1]),
      .sh         (lk_sh[gi+1]),
      .den        (lk_den[gi+1]),
      .side       (lk_side[gi+1])
    );
  end

  assign out_valid = lk_valid[QW];
  assign out_quo   = lk_sh[QW];
  assign out_side  = lk_side[QW];

endmodule

>>> rtl/core/dew_point_from_temp_humidity_unit.sv
// Channel   Handshake                    Payload
// sample    sample_valid / sample_ready  temp_tenths, humidity_pct
// result    result_valid / result_ready  dew_hundredths, invalid
//
// One word per cycle in, one word per cycle out, while the result is not stalled.
// The pipeline holds FRAC_BITS + 3 cells of the a*T/(b+T) divider, the log add
// and multiply registers P1 and P2, 16 cells of the final divider, and the
// output register.
// Synchronous reset clears every valid bit; payload registers are not reset.
// A stalled result freezes the whole chain; sample_ready drops in that cycle.
module dew_point_from_temp_humidity_unit #(
  parameter int FRAC_BITS = dpfth_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic signed [dpfth_pkg::TEMP_W-1:0]  temp_tenths,
  input  logic        [dpfth_pkg::HUM_W-1:0]   humidity_pct,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [dpfth_pkg::DEW_W-1:0]   dew_hundredths,
  output logic                                 invalid
);

  import dpfth_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int DW1   = 16;             // 10*(b10+t) < 2^16
  localparam int QW1   = F + 3;          // |a*T/(b+T)| < 8
  localparam int N1W   = QW1 + DW1;
  localparam int SB1   = HUM_W + 2;
  localparam int LW    = F + 2;          // log10(h/100) in [-2, 0.11)
  localparam int XW    = F + 4;
  localparam int VW    = F + 5;
  localparam int NUMW  = F + 23;
  localparam int DENSW = F + 9;
  localparam int DW2   = F + 8;          // denominator < 256 in Q(F)
  localparam int QW2   = 16;             // |dew| stays below 2^14
  localparam int N2W   = QW2 + DW2;
  localparam int DPW   = QW2 + 1;

  logic en;

  // pipeline moves whenever the output register can take a word
  assign en           = !result_valid || result_ready;
  assign sample_ready = en;

  // ---------------- front: a*T and 10*(b+T) ----------------
  logic              tneg;
  logic [6:0]        a10_in;
  logic [11:0]       b10_in;
  logic signed [17:0] t_ext;
  logic signed [17:0] a_ext;
  logic signed [17:0] prod;
  logic              prod_neg;
  logic [16:0]       prod_mag;
  logic signed [12:0] sum1;
  logic [DW1-1:0]    d1;
  logic [N1W-1:0]    n1;
  logic [SB1-1:0]    side1;

  assign tneg     = temp_tenths[TEMP_W-1];
  assign a10_in   = tneg ? A10_NEG : A10_POS;
  assign b10_in   = tneg ? B10_NEG : B10_POS;
  assign t_ext    = 18'(temp_tenths);
  assign a_ext    = 18'(a10_in);
  assign prod     = t_ext * a_ext;
  assign prod_neg = prod[17];
  assign prod_mag = prod_neg ? 17'(-prod) : 17'(prod);
  assign sum1     = $signed(13'(b10_in)) + 13'(temp_tenths);   // always positive
  assign d1       = DW1'(sum1[11:0]) * DW1'(10);
  // rounded division: add half the divisor to the magnitude
  assign n1       = (N1W'(prod_mag) << F) + N1W'(d1 >> 1);
  assign side1    = {tneg, humidity_pct, prod_neg};

  logic           dv1_valid;
  logic [QW1-1:0] q1;
  logic [SB1-1:0] dv1_side;

  dpfth_div #(.DW(DW1), .QW(QW1), .SBW(SB1)) u_div_ratio (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample_valid),
    .in_num    (n1),
    .in_den    (d1),
    .in_side   (side1),
    .out_valid (dv1_valid),
    .out_quo   (q1),
    .out_side  (dv1_side)
  );

  // ---------------- log table, constant per FRAC_BITS ----------------
  logic signed [LW-1:0] log_tab [1 << HUM_W];

  for (genvar gi = 0; gi < (1 << HUM_W); gi++) begin : g_log
    localparam logic signed [63:0] LV = log10_rel(gi, FRAC_BITS);
    assign log_tab[gi] = LV[LW-1:0];
  end

  // ---------------- stage P1: v = x + log10(RH/100) ----------------
  logic [HUM_W-1:0]  h1;
  logic signed [XW-1:0] x_mag;
  logic signed [XW-1:0] x;
  logic signed [VW-1:0] v_next;

  assign h1     = dv1_side[HUM_W:1];
  assign x_mag  = $signed({1'b0, q1});
  assign x      = dv1_side[0] ? -x_mag : x_mag;
  assign v_next = VW'(x) + VW'(log_tab[h1]);

  logic                 p1_valid;
  logic signed [VW-1:0] p1_v;
  logic                 p1_tneg;
  logic                 p1_hzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= dv1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_v     <= v_next;
      p1_tneg  <= dv1_side[SB1-1];
      p1_hzero <= (h1 == '0);
    end
  end

  // ---------------- stage P2: numerator and denominator ----------------
  logic signed [18:0]     b100;
  logic [6:0]             a10_p;
  logic signed [NUMW-1:0] num_next;
  logic signed [DENSW-1:0] den_s;

  assign b100     = p1_tneg ? $signed(19'(B100_NEG)) : $signed(19'(B100_POS));
  assign a10_p    = p1_tneg ? A10_NEG : A10_POS;
  assign num_next = NUMW'(p1_v) * NUMW'(b100);
  assign den_s    = ($signed(DENSW'(a10_p)) <<< F) - DENSW'(p1_v) * DENSW'(10);

  logic                   p2_valid;
  logic signed [NUMW-1:0] p2_num;
  logic [DW2-1:0]         p2_den;
  logic                   p2_hzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_num   <= num_next;
      p2_den   <= den_s[DW2-1:0];
      p2_hzero <= p1_hzero;
    end
  end

  // ---------------- final divider ----------------
  logic            num_neg;
  logic [NUMW-1:0] num_mag;
  logic [N2W-1:0]  n2;

  assign num_neg = p2_num[NUMW-1];
  assign num_mag = num_neg ? NUMW'(-p2_num) : NUMW'(p2_num);
  assign n2      = N2W'(num_mag) + N2W'(p2_den >> 1);

  logic           dv2_valid;
  logic [QW2-1:0] q2;
  logic [1:0]     dv2_side;

  dpfth_div #(.DW(DW2), .QW(QW2), .SBW(2)) u_div_dew (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_valid),
    .in_num    (n2),
    .in_den    (p2_den),
    .in_side   ({num_neg, p2_hzero}),
    .out_valid (dv2_valid),
    .out_quo   (q2),
    .out_side  (dv2_side)
  );

  // ---------------- sign, clamp, output register ----------------
  logic signed [DPW-1:0]   dp_mag;
  logic signed [DPW-1:0]   dp;
  logic signed [DEW_W-1:0] dew_next;
  logic                    inv_next;

  assign dp_mag = $signed({1'b0, q2});
  assign dp     = dv2_side[1] ? -dp_mag : dp_mag;

  always_comb begin
    if (dv2_side[0]) begin
      dew_next = '0;                       // zero humidity: no log
      inv_next = 1'b1;
    end else if (dp > DPW'(DEW_MAX)) begin
      dew_next = DEW_W'(DEW_MAX);
      inv_next = 1'b1;
    end else if (dp < DPW'(DEW_MIN)) begin
      dew_next = DEW_W'(DEW_MIN);
      inv_next = 1'b1;
    end else begin
      dew_next = dp[DEW_W-1:0];
      inv_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dew_hundredths <= dew_next;
      invalid        <= inv_next;
    end
  end

`ifndef SYNTHESIS
  a_flag_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && invalid |->
      dew_hundredths == '0 || dew_hundredths == DEW_W'(DEW_MAX) ||
      dew_hundredths == DEW_W'(DEW_MIN))
    else $error("invalid flag with unclamped value");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      dew_hundredths <= DEW_W'(DEW_MAX) && dew_hundredths >= DEW_W'(DEW_MIN))
    else $error("dew point out of range");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> den_s != '0 && !den_s[DENSW-1])
    else $error("final divisor not positive");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(p2_valid) && $stable(p1_valid))
    else $error("pipeline moved during stall");
`endif

endmodule

>>> tb/sv/tb.sv
module tb;
  import dpfth_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  // pipeline depth per the header of the unit
  localparam int LAT = FB + 22;

  // clock, reset, ports
  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_ready;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic [HUM_W-1:0] humidity_pct;
  logic result_valid;
  logic result_ready;
  logic signed [DEW_W-1:0] dew_hundredths;
  logic invalid;

  dew_point_from_temp_humidity_unit #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .temp_tenths(temp_tenths), .humidity_pct(humidity_pct),
    .result_valid(result_valid), .result_ready(result_ready),
    .dew_hundredths(dew_hundredths), .invalid(invalid)
  );

  typedef struct packed {
    logic signed [DEW_W-1:0] dew;
    logic inv;
  } dew_word_t;

  // directed stimulus row; has_exp marks rows whose result is typed in
  typedef struct {
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0] h;
    bit has_exp;
    dew_word_t exp;
  } dew_row_t;

  dew_word_t dew_expected_q[$];
  int errors = 0;
  bit stim_done = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // rounded division, half away from zero
  function automatic longint rdiv(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  // log10(h/100) in Q(FB), bitwise log2 at Q32
  function automatic longint log10_ratio(int h);
    int n;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] mag;
    longint l32;
    int s;
    n = 0;
    frac = 0;
    while (n < 6 && (h >> (n + 1)) != 0) n++;
    m = 64'(h) << (30 - n);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[31-i] = 1'b1;
      end
    end
    l32 = longint'(n) * 64'sd1292913986
        + longint'((frac * 64'd1292913986 + (64'd1 << 31)) >> 32)
        - (64'sd2 <<< 32);
    s = 32 - FB;
    if (s == 0) return l32;
    mag = (l32 < 0) ? 64'(-l32) : 64'(l32);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (l32 < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic dew_word_t magnus_dew(logic signed [TEMP_W-1:0] t_in,
                                           logic [HUM_W-1:0] h_in);
    longint t, a10, b10, x, v, num, den, dp;
    dew_word_t r;
    t = t_in;
    r.inv = 0;
    if (h_in == 0) begin
      r.dew = 0;
      r.inv = 1;
      return r;
    end
    if (t >= 0) begin
      a10 = 75; b10 = 2373;
    end else begin
      a10 = 76; b10 = 2407;
    end
    x = rdiv(a10 * t * (64'sd1 <<< FB), 10 * (b10 + t));
    v = x + log10_ratio(h_in);
    num = 100 * b10 * v;
    den = a10 * (64'sd1 <<< FB) - 10 * v;
    dp = rdiv(num, den);
    if (dp > DEW_MAX) begin
      dp = DEW_MAX; r.inv = 1;
    end else if (dp < DEW_MIN) begin
      dp = DEW_MIN; r.inv = 1;
    end
    r.dew = dp[DEW_W-1:0];
    return r;
  endfunction

  // random gap: often none, else mostly short, sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays up after a word so the next one can follow back to back
  task automatic send_word(logic signed [TEMP_W-1:0] t, logic [HUM_W-1:0] h,
                           bit has_exp, dew_word_t exp);
    dew_word_t pred;
    pred = magnus_dew(t, h);
    if (has_exp && pred !== exp) begin
      $error("table row t=%0d h=%0d: table %p, predictor %p", t, h, exp, pred);
      errors++;
    end
    sample_valid <= 1;
    temp_tenths <= t;
    humidity_pct <= h;
    do @(posedge clk); while (!sample_ready);
    dew_expected_q.push_back(has_exp ? exp : pred);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // drop valid between words when n is nonzero
  task automatic sample_gap(int n);
    if (n > 0) begin
      sample_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  dew_row_t dir_tab[$];

  function automatic dew_row_t row(int t, int h, bit he, int d, bit iv);
    dew_row_t r;
    r.t = TEMP_W'(t); r.h = HUM_W'(h); r.has_exp = he;
    r.exp.dew = DEW_W'(d); r.exp.inv = iv;
    return r;
  endfunction

  // stimulus
  initial begin
    int gap;
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0] h;
    rst = 1;
    sample_valid = 0;
    temp_tenths = 0;
    humidity_pct = 0;
    // zero humidity: invalid, result zero
    dir_tab.push_back(row(250, 0, 1, 0, 1));
    dir_tab.push_back(row(-400, 0, 1, 0, 1));
    dir_tab.push_back(row(-1024, 0, 1, 0, 1));
    dir_tab.push_back(row(1023, 0, 1, 0, 1));
    // saturated at 100 %: dew point equals temperature
    dir_tab.push_back(row(0, 100, 1, 0, 0));
    dir_tab.push_back(row(200, 100, 1, 2000, 0));
    dir_tab.push_back(row(-100, 100, 1, -1000, 0));
    dir_tab.push_back(row(800, 100, 0, 0, 0));
    dir_tab.push_back(row(-400, 100, 0, 0, 0));
    // range ends, sign boundary, supersaturation
    dir_tab.push_back(row(800, 1, 0, 0, 0));
    dir_tab.push_back(row(-400, 1, 0, 0, 0));
    dir_tab.push_back(row(-1, 50, 0, 0, 0));
    dir_tab.push_back(row(1, 50, 0, 0, 0));
    dir_tab.push_back(row(800, 127, 0, 0, 0));
    dir_tab.push_back(row(1023, 127, 0, 0, 0));
    dir_tab.push_back(row(-1024, 127, 0, 0, 0));
    dir_tab.push_back(row(-1024, 1, 0, 0, 0));
    dir_tab.push_back(row(1023, 1, 0, 0, 0));
    dir_tab.push_back(row(350, 64, 0, 0, 0));
    dir_tab.push_back(row(-250, 30, 0, 0, 0));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].t, dir_tab[i].h, dir_tab[i].has_exp, dir_tab[i].exp);
      if (i % 4 == 3) sample_gap(gap_len());
    end
    for (int n = 0; n < 850; n++) begin
      // hold off once until the pipe drains
      if (n == 400) begin
        sample_valid <= 0;
        while (dew_expected_q.size() != 0) @(negedge clk);
        idle_cycles(5);
      end
      if ($urandom_range(0, 9) < 8) begin
        t = TEMP_W'($urandom_range(0, 1200) - 400);
        h = HUM_W'($urandom_range(1, 100));
      end else begin
        t = TEMP_W'($urandom());
        h = HUM_W'($urandom());
      end
      send_word(t, h, 0, '0);
      if (n % 150 >= 100) gap = gap_len(); else gap = 0;
      sample_gap(gap);
    end
    sample_valid <= 0;
    stim_done = 1;
  end

  // result side: random stalls, stretches without
  initial begin
    int k;
    result_ready = 0;
    @(negedge clk);
    forever begin
      k = $urandom_range(0, 199);
      if (k < 100) begin
        result_ready <= 1;
        idle_cycles($urandom_range(1, 40));
      end else begin
        result_ready <= 0;
        idle_cycles(gap_len() + 1);
        result_ready <= 1;
        idle_cycles($urandom_range(1, 6));
      end
    end
  end

  // checker
  always @(posedge clk) begin
    dew_word_t e;
    if (!rst && result_valid && result_ready) begin
      if (dew_expected_q.size() == 0) begin
        $error("unexpected result word dew=%0d invalid=%0b", dew_hundredths, invalid);
        errors++;
      end else begin
        e = dew_expected_q.pop_front();
        if (dew_hundredths !== e.dew) begin
          $error("dew_hundredths: expected %0d, actual %0d", e.dew, dew_hundredths);
          errors++;
        end
        if (invalid !== e.inv) begin
          $error("invalid: expected %0b, actual %0b", e.inv, invalid);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (dew_expected_q.size() != 0) @(posedge clk);
    repeat (LAT * 2 + 10) @(posedge clk);
    if (errors == 0 && dew_expected_q.size() == 0)
      $display("** dew_point_from_temp_humidity_unit: PASSED **");
    else
      $display("** dew_point_from_temp_humidity_unit: FAILED **");
    $finish;
  end

  initial begin
    #10000000;
    $display("** dew_point_from_temp_humidity_unit: FAILED **");
    $finish;
  end

endmodule

>>> files.f
rtl/core/dpfth_pkg.sv
rtl/core/dpfth_div_cell.sv
rtl/core/dpfth_div.sv
rtl/core/dew_point_from_temp_humidity_unit.sv
tb/sv/tb.sv
